// File: hw/rtl/dkr_pkg.sv
// Shared types, constants and the key color table for the debounced keypad reporter.
package dkr_pkg;

  localparam int NUM_KEYS  = 6;
  localparam int TIME_BITS = 32;
  localparam int MAX_KEYS  = 8;
  localparam int KEY_IDX_W = 3;

  localparam int DEBOUNCE_W = 16;
  localparam int INTERVAL_W = 16;
  localparam int SLEEP_W    = 20;
  localparam int CFG_DATA_W = 20;
  localparam int CFG_IDX_W  = 2;

  localparam int RAW_W     = 6;
  localparam int STAMP_W   = 32;
  localparam int COLOR_W   = 24;
  localparam int SENDS_W   = 2;

  // Width wide enough for both a time difference and the widest delay register.
  localparam int CMP_W     = (TIME_BITS > SLEEP_W) ? TIME_BITS : SLEEP_W;
  // Width wide enough for both the timestamp port and the internal time.
  localparam int STAMP_EXT_W = (TIME_BITS > STAMP_W) ? TIME_BITS : STAMP_W;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLEEP    = 2'd2;

  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = 16'd50;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 16'd250;
  localparam logic [SLEEP_W-1:0]    SLEEP_RST    = 20'd5000;

  localparam logic [COLOR_W-1:0] COLOR_OFF = 24'h000000;

  typedef logic [TIME_BITS-1:0] time_t;

  // What one lane found for its key in the current poll.
  typedef struct packed {
    logic stable_next;
    logic changed;
    logic rise;
  } lane_t;

  typedef struct packed {
    logic [RAW_W-1:0]   packed_states;
    logic [SENDS_W-1:0] send_count;
    logic               led_write;
    logic [COLOR_W-1:0] led_color;
    logic               sleep_request;
  } result_t;

  // Keys six and seven reuse the colors of keys zero and one.
  function automatic logic [COLOR_W-1:0] key_color(input logic [KEY_IDX_W-1:0] idx);
    logic [COLOR_W-1:0] color;
    unique case (idx)
      3'd0:    color = 24'hFF9800;
      3'd1:    color = 24'hD32F2F;
      3'd2:    color = 24'h2196F3;
      3'd3:    color = 24'h4CAF50;
      3'd4:    color = 24'h9C27B0;
      3'd5:    color = 24'h00BCD4;
      3'd6:    color = 24'hFF9800;
      default: color = 24'hD32F2F;
    endcase
    return color;
  endfunction

endpackage

// File: hw/rtl/debounced_keypad_reporter.sv
// Top level of the debounced keypad reporter: config registers, key lanes, merge and output stage.
// A poll transferred at an edge is registered in the output register, or in the skid stage if stalled.
// Throughput: one poll per cycle while in_stall is low; lanes and merging stage are combinational.
// A stalled output parks one result in a skid stage; while it is full, in_stall stalls the input.
// Reset (rst, synchronous, active high) clears all key states and timers, arms sleep,
// empties the output stage and loads the config registers with 50, 250 and 5000 ms.
module debounced_keypad_reporter (
  input  logic                               clk,
  input  logic                               rst,

  input  logic                               cfg_write,
  input  logic [dkr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dkr_pkg::CFG_DATA_W-1:0]     cfg_data,

  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [dkr_pkg::RAW_W-1:0]          raw_levels,
  input  logic [dkr_pkg::STAMP_W-1:0]        time_now,

  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [dkr_pkg::RAW_W-1:0]          packed_states,
  output logic [dkr_pkg::SENDS_W-1:0]        send_count,
  output logic                               led_write,
  output logic [dkr_pkg::COLOR_W-1:0]        led_color,
  output logic                               sleep_request
);

  logic [dkr_pkg::DEBOUNCE_W-1:0] debounce_ms;
  logic [dkr_pkg::INTERVAL_W-1:0] update_interval_ms;
  logic [dkr_pkg::SLEEP_W-1:0]    sleep_delay_ms;

  logic                             accept;
  logic [dkr_pkg::MAX_KEYS-1:0]     raw_ext;
  logic [dkr_pkg::STAMP_EXT_W-1:0]  stamp_ext;
  dkr_pkg::time_t                   now;
  dkr_pkg::lane_t                   lanes [dkr_pkg::NUM_KEYS];
  dkr_pkg::result_t                 result;
  dkr_pkg::result_t                 out_data;

  // Configuration writes land directly; an index past the last register is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms        <= dkr_pkg::DEBOUNCE_RST;
      update_interval_ms <= dkr_pkg::INTERVAL_RST;
      sleep_delay_ms     <= dkr_pkg::SLEEP_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        dkr_pkg::REG_DEBOUNCE: debounce_ms        <= cfg_data[dkr_pkg::DEBOUNCE_W-1:0];
        dkr_pkg::REG_INTERVAL: update_interval_ms <= cfg_data[dkr_pkg::INTERVAL_W-1:0];
        dkr_pkg::REG_SLEEP:    sleep_delay_ms     <= cfg_data[dkr_pkg::SLEEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // A poll is taken at every edge where the output stage still has room.
  assign accept = in_valid && !in_stall;

  // Raw bits above the key count are ignored; the timestamp wraps at the internal time width.
  assign raw_ext   = dkr_pkg::MAX_KEYS'(raw_levels);
  assign stamp_ext = dkr_pkg::STAMP_EXT_W'(time_now);
  assign now       = stamp_ext[dkr_pkg::TIME_BITS-1:0];

  // One lane per key: each tracks its own level, restart time and stable state.
  for (genvar k = 0; k < dkr_pkg::NUM_KEYS; k++) begin : g_lane
    dkr_lane u_lane (
      .clk         (clk),
      .rst         (rst),
      .accept      (accept),
      .raw_bit     (raw_ext[k]),
      .now         (now),
      .debounce_ms (debounce_ms),
      .lane        (lanes[k])
    );
  end

  // The merging stage owns the global timers: last periodic send, release time, sleep arming.
  dkr_merge u_merge (
    .clk                (clk),
    .rst                (rst),
    .accept             (accept),
    .lanes              (lanes),
    .now                (now),
    .update_interval_ms (update_interval_ms),
    .sleep_delay_ms     (sleep_delay_ms),
    .result             (result)
  );

  // The result of every transfer goes into the output register, or the skid stage if stalled.
  dkr_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_data   (result),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

  assign packed_states = out_data.packed_states;
  assign send_count    = out_data.send_count;
  assign led_write     = out_data.led_write;
  assign led_color     = out_data.led_color;
  assign sleep_request = out_data.sleep_request;

  // The skid stage only fills behind a valid output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("skid stage holds a result while the output register is empty");

  // A sleep request always writes the LED off.
  a_sleep_led_off: assert property (@(posedge clk) disable iff (rst)
    (out_valid && sleep_request) |-> (led_write && (led_color == dkr_pkg::COLOR_OFF)))
    else $error("sleep request without an LED off write");

  // Once the output drains with no new poll offered, the input side is free again.
  a_stall_clears: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !in_valid) |=> !in_stall)
    else $error("input still stalled after the output drained");

endmodule

// File: hw/rtl/dkr_lane.sv
// One debounce lane: holds the last reading, change time and stable state of one key.
module dkr_lane (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               accept,
  input  logic                               raw_bit,
  input  dkr_pkg::time_t                     now,
  input  logic [dkr_pkg::DEBOUNCE_W-1:0]     debounce_ms,
  output dkr_pkg::lane_t                     lane
);

  logic           last_bit;
  logic           stable_bit;
  dkr_pkg::time_t change_time;
  dkr_pkg::time_t change_time_next;
  dkr_pkg::time_t elapsed;
  logic           settled;
  logic           flip;

  // A level change restarts the debounce time at this poll.
  assign change_time_next = (raw_bit != last_bit) ? now : change_time;
  assign elapsed          = now - change_time_next;
  assign settled          = dkr_pkg::CMP_W'(elapsed) > dkr_pkg::CMP_W'(debounce_ms);
  assign flip             = settled && (raw_bit != stable_bit);

  assign lane.changed     = flip;
  assign lane.rise        = flip & raw_bit;
  assign lane.stable_next = flip ? raw_bit : stable_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_bit    <= 1'b0;
      stable_bit  <= 1'b0;
      change_time <= '0;
    end else if (accept) begin
      last_bit    <= raw_bit;
      stable_bit  <= lane.stable_next;
      change_time <= change_time_next;
    end
  end

endmodule

// File: hw/rtl/dkr_merge.sv
// Merging stage: combines the lane findings into sends, LED writes and the sleep request.
module dkr_merge (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               accept,
  input  dkr_pkg::lane_t                     lanes [dkr_pkg::NUM_KEYS],
  input  dkr_pkg::time_t                     now,
  input  logic [dkr_pkg::INTERVAL_W-1:0]     update_interval_ms,
  input  logic [dkr_pkg::SLEEP_W-1:0]        sleep_delay_ms,
  output dkr_pkg::result_t                   result
);

  logic           prev_any_held;
  logic           sleep_armed;
  dkr_pkg::time_t last_send_time;
  dkr_pkg::time_t release_time;

  logic [dkr_pkg::MAX_KEYS-1:0]  stable_ext;
  logic                          changed;
  logic                          rise_any;
  logic                          any_held;
  logic [dkr_pkg::KEY_IDX_W-1:0] active;
  logic                          released;
  logic                          periodic;
  logic                          sleep_armed_next;
  dkr_pkg::time_t                release_time_next;
  dkr_pkg::time_t                send_elapsed;
  dkr_pkg::time_t                idle_elapsed;
  logic                          sleep_req;
  logic [dkr_pkg::COLOR_W-1:0]   color;

  always_comb begin
    stable_ext = '0;
    changed    = 1'b0;
    rise_any   = 1'b0;
    active     = '0;
    for (int i = 0; i < dkr_pkg::NUM_KEYS; i++) begin
      stable_ext[i] = lanes[i].stable_next;
      changed       = changed | lanes[i].changed;
      if (lanes[i].rise) begin
        rise_any = 1'b1;
        active   = dkr_pkg::KEY_IDX_W'(i);
      end
    end
  end

  assign any_held = |stable_ext;
  assign released = !any_held && prev_any_held;

  // A new press disarms sleep; a full release re-arms it and restarts the idle time.
  assign sleep_armed_next  = released ? 1'b1 : (rise_any ? 1'b0 : sleep_armed);
  assign release_time_next = released ? now : release_time;

  assign send_elapsed = now - last_send_time;
  assign periodic     = any_held &&
                        (dkr_pkg::CMP_W'(send_elapsed) > dkr_pkg::CMP_W'(update_interval_ms));

  assign idle_elapsed = now - release_time_next;
  assign sleep_req    = sleep_armed_next &&
                        (dkr_pkg::CMP_W'(idle_elapsed) > dkr_pkg::CMP_W'(sleep_delay_ms));

  assign color = (released || sleep_req || !rise_any) ? dkr_pkg::COLOR_OFF
                                                      : dkr_pkg::key_color(active);

  assign result.packed_states = stable_ext[dkr_pkg::RAW_W-1:0];
  assign result.send_count    = {1'b0, changed} + {1'b0, released} + {1'b0, periodic};
  assign result.led_write     = changed | released | sleep_req;
  assign result.led_color     = color;
  assign result.sleep_request = sleep_req;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_any_held  <= 1'b0;
      sleep_armed    <= 1'b1;
      last_send_time <= '0;
      release_time   <= '0;
    end else if (accept) begin
      prev_any_held <= any_held;
      sleep_armed   <= sleep_armed_next;
      release_time  <= release_time_next;
      if (periodic) begin
        last_send_time <= now;
      end
    end
  end

endmodule

// File: hw/rtl/dkr_outbuf.sv
// Output register with a skid stage so the input side can take one more poll under a stall.
module dkr_outbuf (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  dkr_pkg::result_t in_data,
  output logic             in_stall,
  output logic             out_valid,
  output dkr_pkg::result_t out_data,
  input  logic             out_stall
);

  logic             skid_valid;
  dkr_pkg::result_t skid_data;
  logic             push;
  logic             pop;

  assign in_stall = skid_valid;
  assign push     = in_valid && !skid_valid;
  assign pop      = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop || !out_valid) begin
      out_valid  <= skid_valid | push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop || !out_valid) begin
      out_data <= skid_valid ? skid_data : in_data;
    end else if (push) begin
      skid_data <= in_data;
    end
  end

endmodule

// File: tb/sv/keypad_report_checker.sv
`timescale 1ns / 1ps
// Watches both channels and the register port, predicts each report and compares it.
module keypad_report_checker
  import dkr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [RAW_W-1:0]     raw_levels,
  input  logic [STAMP_W-1:0]   time_now,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [RAW_W-1:0]     packed_states,
  input  logic [SENDS_W-1:0]   send_count,
  input  logic                 led_write,
  input  logic [COLOR_W-1:0]   led_color,
  input  logic                 sleep_request,
  output int                   fail_count,
  output int                   pending_results
);

  logic [DEBOUNCE_W-1:0] debounce_len;
  logic [INTERVAL_W-1:0] resend_gap;
  logic [SLEEP_W-1:0]    sleep_after;

  logic [RAW_W-1:0] stable_keys;
  logic [RAW_W-1:0] prior_raw;
  time_t            press_stamp [NUM_KEYS];
  time_t            resend_stamp;
  time_t            release_stamp;
  logic             sleep_ready;
  logic             held_before;

  result_t expected_reports [$];
  int      errors = 0;

  function automatic logic [COLOR_W-1:0] key_led_rgb(input int key);
    case (key)
      0:       return 24'hFF9800;
      1:       return 24'hD32F2F;
      2:       return 24'h2196F3;
      3:       return 24'h4CAF50;
      4:       return 24'h9C27B0;
      default: return 24'h00BCD4;
    endcase
  endfunction

  task automatic clear_keypad();
    debounce_len  = DEBOUNCE_RST;
    resend_gap    = INTERVAL_RST;
    sleep_after   = SLEEP_RST;
    stable_keys   = '0;
    prior_raw     = '0;
    for (int k = 0; k < NUM_KEYS; k++) press_stamp[k] = '0;
    resend_stamp  = '0;
    release_stamp = '0;
    sleep_ready   = 1'b1;
    held_before   = 1'b0;
    expected_reports.delete();
  endtask

  // One poll: debounce every key, then count sends, pick the LED write and check sleep.
  task automatic predict_report(input logic [RAW_W-1:0] raw, input time_t stamp,
                                output result_t res);
    logic               changed;
    logic               any;
    logic               led_wr;
    logic               sleep_req;
    int                 newest;
    logic [SENDS_W-1:0] sends;
    logic [COLOR_W-1:0] color;
    time_t              span;
    changed   = 1'b0;
    any       = 1'b0;
    led_wr    = 1'b0;
    sleep_req = 1'b0;
    newest    = -1;
    sends     = '0;
    color     = COLOR_OFF;
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (raw[k] != prior_raw[k]) press_stamp[k] = stamp;
      span = stamp - press_stamp[k];
      if (span > time_t'(debounce_len) && raw[k] != stable_keys[k]) begin
        stable_keys[k] = raw[k];
        changed = 1'b1;
        if (raw[k]) begin
          newest      = k;
          any         = 1'b1;
          sleep_ready = 1'b0;
        end
      end
      if (stable_keys[k]) any = 1'b1;
    end
    prior_raw = raw;
    if (changed) begin
      led_wr = 1'b1;
      color  = (newest >= 0) ? key_led_rgb(newest) : COLOR_OFF;
      sends++;
    end
    if (!any && held_before) begin
      release_stamp = stamp;
      sleep_ready   = 1'b1;
      led_wr        = 1'b1;
      color         = COLOR_OFF;
      sends++;
    end
    held_before = any;
    span = stamp - resend_stamp;
    if (any && span > time_t'(resend_gap)) begin
      sends++;
      resend_stamp = stamp;
    end
    span = stamp - release_stamp;
    if (sleep_ready && span > time_t'(sleep_after)) begin
      sleep_req = 1'b1;
      led_wr    = 1'b1;
      color     = COLOR_OFF;
    end
    res.packed_states = stable_keys;
    res.send_count    = sends;
    res.led_write     = led_wr;
    res.led_color     = led_wr ? color : COLOR_OFF;
    res.sleep_request = sleep_req;
  endtask

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    result_t got;
    if (rst) begin
      clear_keypad();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_DEBOUNCE: debounce_len = cfg_data[DEBOUNCE_W-1:0];
          REG_INTERVAL: resend_gap   = cfg_data[INTERVAL_W-1:0];
          REG_SLEEP:    sleep_after  = cfg_data[SLEEP_W-1:0];
          default:      ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got = '{packed_states, send_count, led_write, led_color, sleep_request};
        if (expected_reports.size() == 0) begin
          errors++;
          $display("%0t: unexpected report, expected none, actual %0h", $time, got);
        end else begin
          want = expected_reports.pop_front();
          compare_field("packed_states", 32'(want.packed_states), 32'(got.packed_states));
          compare_field("send_count", 32'(want.send_count), 32'(got.send_count));
          compare_field("led_write", 32'(want.led_write), 32'(got.led_write));
          compare_field("led_color", 32'(want.led_color), 32'(got.led_color));
          compare_field("sleep_request", 32'(want.sleep_request), 32'(got.sleep_request));
        end
      end
      if (in_valid && !in_stall) begin
        predict_report(raw_levels, time_now, want);
        expected_reports.push_back(want);
      end
    end
    fail_count      <= errors;
    pending_results <= expected_reports.size();
  end

endmodule

// File: tb/sv/debounced_keypad_reporter_test.sv
`timescale 1ns / 1ps
// Testbench top for the keypad reporter: clock, reset, poll stimulus, back-pressure and verdict.
module debounced_keypad_reporter_test;
  import dkr_pkg::*;

  // Index 3 has no register behind it; writes there must leave the timing untouched.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  // Cycles without any transfer before the run is declared hung. The long output
  // hold below is the slowest legal stretch, so the limit sits well above it.
  localparam int STUCK_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_POLLS = 330;

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [RAW_W-1:0]      raw_levels;
  logic [STAMP_W-1:0]    time_now;
  logic                  out_valid;
  logic                  out_stall;
  logic [RAW_W-1:0]      packed_states;
  logic [SENDS_W-1:0]    send_count;
  logic                  led_write;
  logic [COLOR_W-1:0]    led_color;
  logic                  sleep_request;

  int fail_count;
  int pending_results;

  // Stimulus bookkeeping: the running millisecond clock, the raw pattern the
  // keys are resting at, and a copy of the timing registers to scale steps.
  logic [STAMP_W-1:0]    now_ms;
  logic [RAW_W-1:0]      held;
  int                    poll_total;
  int                    settings_used;
  logic [DEBOUNCE_W-1:0] debounce_cfg;
  logic [INTERVAL_W-1:0] interval_cfg;
  logic [SLEEP_W-1:0]    sleep_cfg;

  // calm switches idling off on both sides; each bump of hold_requests asks the
  // result side for one long stall.
  logic calm;
  int   hold_requests;

  debounced_keypad_reporter dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .raw_levels    (raw_levels),
    .time_now      (time_now),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .packed_states (packed_states),
    .send_count    (send_count),
    .led_write     (led_write),
    .led_color     (led_color),
    .sleep_request (sleep_request)
  );

  keypad_report_checker report_check (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .raw_levels      (raw_levels),
    .time_now        (time_now),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .packed_states   (packed_states),
    .send_count      (send_count),
    .led_write       (led_write),
    .led_color       (led_color),
    .sleep_request   (sleep_request),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Offer one poll, idling first at random. The payload stays put while the
  // block stalls, and the task returns at the edge where the transfer happens.
  task automatic send_poll(input logic [RAW_W-1:0] raw, input logic [STAMP_W-1:0] stamp);
    while (!calm && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    raw_levels <= raw;
    time_now   <= stamp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    poll_total++;
  endtask

  // Drive one register write for a single cycle; the caller lowers the enable.
  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // Load all three timing registers. The narrow registers get random junk in the
  // unused upper data bits, and a stray write to the spare index follows.
  task automatic set_timing(input logic [DEBOUNCE_W-1:0] deb,
                            input logic [INTERVAL_W-1:0] intv,
                            input logic [SLEEP_W-1:0] slp);
    put_reg(REG_DEBOUNCE, {4'($urandom()), deb});
    put_reg(REG_INTERVAL, {4'($urandom()), intv});
    put_reg(REG_SLEEP, slp);
    put_reg(REG_SPARE, CFG_DATA_W'($urandom()));
    cfg_write    <= 1'b0;
    debounce_cfg = deb;
    interval_cfg = intv;
    sleep_cfg    = slp;
    settings_used++;
  endtask

  // Stop offering and wait until every predicted report has been transferred,
  // then a few more cycles so the block is surely idle.
  task automatic settle(input int tail);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  // Random key activity. Most of it is gestures: pick a new key pattern, bounce
  // the changing keys for a few polls, then hold the pattern for a span sized
  // around the debounce time (sometimes too short, sometimes long enough for
  // periodic resends). The rest is noise polls, timestamp jumps, mostly near the wrap
  // point, and long quiet gaps after a full release that can reach the sleep timeout.
  task automatic run_gestures(input int quota);
    int               first;
    int               kind;
    int               shape;
    int               goal;
    int               span;
    int               step_top;
    int               st;
    logic [RAW_W-1:0] flip;
    logic [RAW_W-1:0] target;
    first = poll_total;
    while (poll_total - first < quota) begin
      kind = $urandom_range(99);
      if (kind < 12) begin
        now_ms = now_ms + $urandom_range(0, 300);
        send_poll(RAW_W'($urandom()), now_ms);
      end else if (kind < 16) begin
        if (kind == 12) now_ms = $urandom();
        else now_ms = 32'hFFFF_FFFF - $urandom_range(0, 200);
        send_poll(held, now_ms);
      end else begin
        if (kind < 60) flip = RAW_W'(1) << $urandom_range(0, RAW_W - 1);
        else if (kind < 92) flip = RAW_W'($urandom());
        else flip = held;
        target = held ^ flip;
        shape  = $urandom_range(4);
        if (shape == 0) goal = $urandom_range(0, debounce_cfg);
        else if (shape == 1) goal = debounce_cfg + $urandom_range(0, 2 * interval_cfg + 2);
        else goal = debounce_cfg + $urandom_range(1, 8);
        step_top = goal / 5 + 1;
        repeat ($urandom_range(0, 3)) begin
          now_ms = now_ms + $urandom_range(0, step_top / 2);
          send_poll(target ^ (flip & RAW_W'($urandom())), now_ms);
        end
        span = 0;
        do begin
          st     = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, step_top);
          now_ms = now_ms + st;
          span   = span + st;
          send_poll(target, now_ms);
        end while (span <= goal);
        held = target;
        if (target == '0 && $urandom_range(3) == 0) begin
          now_ms = now_ms + $urandom_range(0, 2 * sleep_cfg + 2);
          send_poll('0, now_ms);
        end
      end
    end
  endtask

  // Result side: random stalls, none while calm, and one long hold-off per
  // request so the output skid fills and the block stalls its input.
  initial begin : result_sink
    int served;
    int hold_left;
    served    = 0;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && served != hold_requests) begin
        served    = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 30);
      end
    end
  end

  // Any stretch with no transfer on either channel longer than the limit means
  // the block has hung or lost a report.
  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck = 0;
      else stuck++;
    end
    $display("%0t: no transfer for %0d cycles", $time, STUCK_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    rst           <= 1'b1;
    cfg_write     <= 1'b0;
    cfg_index     <= REG_DEBOUNCE;
    cfg_data      <= '0;
    in_valid      <= 1'b0;
    raw_levels    <= '0;
    time_now      <= '0;
    calm          <= 1'b0;
    hold_requests <= 0;
    now_ms        = '0;
    held          = '0;
    poll_total    = 0;
    settings_used = 1;
    debounce_cfg  = DEBOUNCE_RST;
    interval_cfg  = INTERVAL_RST;
    sleep_cfg     = SLEEP_RST;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed polls with the reset timing of 50, 250 and 5000 ms.
    send_poll(6'h00, 32'd0);          // quiet start, nothing due
    send_poll(6'h3F, 32'd10);         // every key goes down at once
    send_poll(6'h3F, 32'd60);         // exactly the debounce time: not yet stable
    send_poll(6'h3F, 32'd61);         // one past it: all stable, newest key's color
    send_poll(6'h3F, 32'd400);        // held past the resend interval
    send_poll(6'h00, 32'd401);        // bounce on release
    send_poll(6'h3F, 32'd402);
    send_poll(6'h00, 32'd403);
    send_poll(6'h00, 32'd454);        // release settles: change plus full release
    send_poll(6'h00, 32'd5454);       // exactly the release timeout: no sleep request yet
    send_poll(6'h00, 32'd5455);       // one past it: sleep request while armed
    send_poll(6'h01, 32'd5460);       // key 0 alone
    send_poll(6'h01, 32'd5520);
    send_poll(6'h21, 32'd5530);       // key 5 joins
    send_poll(6'h21, 32'd5590);
    send_poll(6'h02, 32'hFFFF_FFF0);  // keys 0 and 5 up, key 1 down, just before wrap
    send_poll(6'h02, 32'hFFFF_FFFF);  // all ones timestamp
    send_poll(6'h02, 32'h0000_0030);  // settles across the wrap
    send_poll(6'h00, 32'h0000_0040);
    send_poll(6'h00, 32'h0000_0100);  // full release after wrap
    now_ms = 32'h0000_0100;
    held   = '0;
    settle(2);

    // Random phases: reset timing, all zero with no idling, full scale with a
    // long output hold, then random and short random timing, and back to reset.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        1: begin
          set_timing('0, '0, '0);
          calm <= 1'b1;
        end
        2: begin
          calm <= 1'b0;
          set_timing('1, '1, '1);
          hold_requests <= hold_requests + 1;
        end
        3: set_timing(DEBOUNCE_W'($urandom()), INTERVAL_W'($urandom()),
                      SLEEP_W'($urandom()));
        4: set_timing(DEBOUNCE_W'($urandom_range(1, 30)), INTERVAL_W'($urandom_range(0, 100)),
                      SLEEP_W'($urandom_range(0, 500)));
        5: set_timing(DEBOUNCE_RST, INTERVAL_RST, SLEEP_RST);
        default: ;
      endcase
      run_gestures(PHASE_POLLS);
      settle(2);
    end
    settle(4);

    $display("Summary: %0d polls under %0d timing settings, zero and full scale included,",
             poll_total, settings_used);
    $display("with bouncing keys, timestamp wrap, sleep timeouts and a %0d-cycle output hold.",
             HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: debounced_keypad_reporter.f
hw/rtl/dkr_pkg.sv
hw/rtl/dkr_lane.sv
hw/rtl/dkr_merge.sv
hw/rtl/dkr_outbuf.sv
hw/rtl/debounced_keypad_reporter.sv
tb/sv/keypad_report_checker.sv
tb/sv/debounced_keypad_reporter_test.sv
